@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files (included by gbn_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define GBN_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("gbn: invariant violated");

`define GBN_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbn: implication violated");

`define GBN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbn: next-cycle check violated");

`else

`define GBN_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define GBN_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define GBN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/gbn_pkg.sv @@
// Shared types, codes and sizes of the go-back-N sender core
package gbn_pkg;

    // Window storage; the slot of a sequence is tracked as it advances, so any size works
    localparam int WINDOW_MAX = 32;
    localparam int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    localparam int SEQ_W      = 32;
    localparam int TICK_W     = 32;
    localparam int KIND_W     = 2;
    localparam int TYPE_W     = 2;
    localparam int WIN_W      = 6;
    localparam int CHUNK_W    = 32;
    localparam int TOUT_W     = 16;
    localparam int TOKEN_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Input kinds
    localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RX    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    // Received packet types
    localparam logic [TYPE_W-1:0] PKT_ACK = 2'd3;

    // Result types
    localparam logic [TYPE_W-1:0] SEND_START = 2'd0;
    localparam logic [TYPE_W-1:0] SEND_END   = 2'd1;
    localparam logic [TYPE_W-1:0] SEND_DATA  = 2'd2;
    localparam logic [TYPE_W-1:0] SEND_DONE  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIN_SIZE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_TOKEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_TOKEN     = 3'd4;

    // Configuration defaults
    localparam logic [WIN_W-1:0]   WIN_SIZE_RST      = 6'd8;
    localparam logic [CHUNK_W-1:0] CHUNK_COUNT_RST   = 32'd0;
    localparam logic [TOUT_W-1:0]  TIMEOUT_TICKS_RST = 16'd500;
    localparam logic [TOKEN_W-1:0] START_TOKEN_RST   = 32'd0;
    localparam logic [TOKEN_W-1:0] END_TOKEN_RST     = 32'd0;

    typedef enum logic [1:0] {
        OP_BEGIN,
        OP_ACK,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SEQ_W-1:0] seq;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_beat;

    typedef struct packed {
        logic [WIN_W-1:0]   win_size;
        logic [CHUNK_W-1:0] chunk_count;
        logic [TOUT_W-1:0]  timeout_ticks;
        logic [TOKEN_W-1:0] start_token;
        logic [TOKEN_W-1:0] end_token;
    } t_cfg;

endpackage

@@ hw/rtl/gbn_if.sv @@
// Valid/ready channel interfaces for event input and send output
interface gbn_in_if;
    logic                        valid;
    logic                        ready;
    logic [gbn_pkg::KIND_W-1:0]  kind;
    logic [gbn_pkg::TYPE_W-1:0]  rx_type;
    logic [gbn_pkg::SEQ_W-1:0]   rx_seq;

    modport source (output valid, kind, rx_type, rx_seq, input ready);
    modport sink   (input valid, kind, rx_type, rx_seq, output ready);
endinterface

interface gbn_out_if;
    logic                        valid;
    logic                        ready;
    logic [gbn_pkg::TYPE_W-1:0]  send_type;
    logic [gbn_pkg::SEQ_W-1:0]   send_seq;
    logic                        last;

    modport source (output valid, send_type, send_seq, last, input ready);
    modport sink   (input valid, send_type, send_seq, last, output ready);
endinterface

@@ hw/rtl/gbn_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/gbn_front.sv @@
// Front end: accept event beats, drop those with no effect, stage commands
module gbn_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gbn_in_if.sink             i_in,
    input  logic               i_full,
    output gbn_pkg::t_cmd_beat o_enq
);

    logic          r_valid;
    gbn_pkg::t_cmd r_cmd;
    gbn_pkg::t_cmd n_cmd;
    logic          keep;
    logic          take;

    // Stage frees up when it is empty or its command moves into the queue
    assign take       = !r_valid || !i_full;
    assign i_in.ready = take;

    always_comb begin
        keep      = 1'b0;
        n_cmd.op  = gbn_pkg::OP_TICK;
        n_cmd.seq = i_in.rx_seq;
        case (i_in.kind)
            gbn_pkg::KIND_BEGIN: begin
                keep     = 1'b1;
                n_cmd.op = gbn_pkg::OP_BEGIN;
            end
            gbn_pkg::KIND_RX: begin
                // only ACKs matter to a sender
                keep     = (i_in.rx_type == gbn_pkg::PKT_ACK);
                n_cmd.op = gbn_pkg::OP_ACK;
            end
            gbn_pkg::KIND_TICK: begin
                keep     = 1'b1;
                n_cmd.op = gbn_pkg::OP_TICK;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_in.valid && keep;
        end
        if (take && i_in.valid && keep) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_enq.valid = r_valid;
    assign o_enq.cmd   = r_cmd;

endmodule

@@ hw/rtl/gbn_queue.sv @@
// Short command queue between the front end and the executor
module gbn_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gbn_pkg::t_cmd_beat i_enq,
    output logic               o_full,
    output gbn_pkg::t_cmd_beat o_deq,
    input  logic               i_pop
);

    gbn_pkg::t_cmd                 r_mem [gbn_pkg::QUEUE_DEPTH];
    logic [gbn_pkg::Q_PTR_W-1:0]   r_wr;
    logic [gbn_pkg::Q_PTR_W-1:0]   r_rd;
    logic [gbn_pkg::Q_CNT_W-1:0]   r_cnt;
    logic                          push;
    logic                          pop;

    function automatic logic [gbn_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [gbn_pkg::Q_PTR_W-1:0] p
    );
        if (p == gbn_pkg::Q_PTR_W'(gbn_pkg::QUEUE_DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + 1'b1;
        end
    endfunction

    assign o_full = (r_cnt == gbn_pkg::Q_CNT_W'(gbn_pkg::QUEUE_DEPTH));
    assign push   = i_enq.valid && !o_full;
    assign pop    = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr] <= i_enq.cmd;
        end
    end

    assign o_deq.valid = (r_cnt != '0);
    assign o_deq.cmd   = r_mem[r_rd];

endmodule

@@ hw/rtl/gbn_back.sv @@
// Executor: window state, timestamps and one send beat per cycle while the output is not stalled
`include "assert_macros.svh"

module gbn_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gbn_pkg::t_cfg      i_cfg,
    input  gbn_pkg::t_cmd_beat i_deq,
    output logic               o_pop,
    gbn_out_if.source          o_out
);

    localparam int WINDOW_MAX = gbn_pkg::WINDOW_MAX;
    localparam int SLOT_W     = gbn_pkg::SLOT_W;
    localparam int CNT_W      = gbn_pkg::CNT_W;
    localparam int SEQ_W      = gbn_pkg::SEQ_W;
    localparam int TICK_W     = gbn_pkg::TICK_W;
    localparam int TYPE_W     = gbn_pkg::TYPE_W;

    localparam logic [CNT_W:0]   WMAX_EXT = (CNT_W + 1)'(WINDOW_MAX);
    localparam logic [SEQ_W-1:0] SPAN_MAX = SEQ_W'(WINDOW_MAX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_FILL,
        S_RESEND,
        S_PUT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START_WAIT,
        PH_DATA,
        PH_END_WAIT
    } t_phase;

    t_state              r_state;
    t_phase              r_phase;
    logic [SEQ_W-1:0]    r_low_mark;
    logic [SEQ_W-1:0]    r_next_seq;
    logic [SLOT_W-1:0]   r_low_slot;
    logic [SLOT_W-1:0]   r_next_slot;
    logic [TICK_W-1:0]   r_now;
    logic [TICK_W-1:0]   r_hs_at;
    logic [SEQ_W-1:0]    r_cur_seq;
    logic [SLOT_W-1:0]   r_cur_slot;
    logic [CNT_W-1:0]    r_cnt;
    logic [TYPE_W-1:0]   r_put_type;
    logic [SEQ_W-1:0]    r_put_seq;
    logic                r_out_valid;
    logic [TYPE_W-1:0]   r_out_type;
    logic [SEQ_W-1:0]    r_out_seq;
    logic                r_out_last;

    logic                out_free;
    logic [CNT_W-1:0]    w_lim;
    logic [SEQ_W-1:0]    seq_span;
    logic [CNT_W-1:0]    outst;
    logic [SEQ_W-1:0]    seq_inc;
    logic                can_send;
    logic                can_send_more;
    logic [SEQ_W-1:0]    ack_seq;
    logic [SEQ_W-1:0]    ack_span;
    logic                ack_ok;
    logic [CNT_W:0]      slot_sum;
    logic [SLOT_W-1:0]   ack_slot;
    logic [TICK_W-1:0]   ring_q;
    logic [TICK_W-1:0]   hs_age;
    logic [TICK_W-1:0]   ring_age;
    logic [TICK_W-1:0]   tout;
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        if (s == SLOT_W'(WINDOW_MAX - 1)) begin
            slot_inc = '0;
        end else begin
            slot_inc = s + 1'b1;
        end
    endfunction

    assign out_free = !r_out_valid || o_out.ready;

    // Window limit: zero acts as one, anything above the ring saturates
    always_comb begin
        if (i_cfg.win_size == '0) begin
            w_lim = CNT_W'(1);
        end else if (32'(i_cfg.win_size) > 32'(WINDOW_MAX)) begin
            w_lim = CNT_W'(WINDOW_MAX);
        end else begin
            w_lim = CNT_W'(i_cfg.win_size);
        end
    end

    // Outstanding count never exceeds the ring, so the low bits carry it
    assign seq_span = r_next_seq - r_low_mark;
    assign outst    = seq_span[CNT_W-1:0];
    assign seq_inc  = r_next_seq + 1'b1;

    assign can_send      = (r_next_seq < i_cfg.chunk_count) && (outst < w_lim);
    assign can_send_more = (seq_inc < i_cfg.chunk_count)
                           && (({1'b0, outst} + 1'b1) < {1'b0, w_lim});

    // Cumulative ACK: move the low slot by the number of retired packets
    assign ack_seq  = i_deq.cmd.seq;
    assign ack_span = ack_seq - r_low_mark;
    assign ack_ok   = (ack_seq > r_low_mark) && (ack_seq <= r_next_seq);
    assign slot_sum = (CNT_W + 1)'(r_low_slot) + (CNT_W + 1)'(ack_span[CNT_W-1:0]);

    always_comb begin
        if (slot_sum >= WMAX_EXT) begin
            ack_slot = SLOT_W'(slot_sum - WMAX_EXT);
        end else begin
            ack_slot = SLOT_W'(slot_sum);
        end
    end

    assign tout     = TICK_W'(i_cfg.timeout_ticks);
    assign hs_age   = r_now - r_hs_at;
    assign ring_age = r_now - ring_q;

    assign o_pop     = (r_state == S_IDLE) && i_deq.valid;
    assign ram_we    = out_free && (((r_state == S_FILL) && can_send) || (r_state == S_RESEND));
    assign ram_waddr = (r_state == S_RESEND) ? r_cur_slot : r_next_slot;

    // Send time of each outstanding packet, read at the oldest slot
    gbn_ram #(
        .WIDTH (TICK_W),
        .DEPTH (WINDOW_MAX)
    ) u_sent_at (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_now),
        .i_raddr (r_low_slot),
        .o_rdata (ring_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_low_mark  <= '0;
            r_next_seq  <= '0;
            r_low_slot  <= '0;
            r_next_slot <= '0;
            r_now       <= '0;
            r_hs_at     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_deq.valid) begin
                        case (i_deq.cmd.op)
                            gbn_pkg::OP_BEGIN: begin
                                if (r_phase == PH_IDLE) begin
                                    r_low_mark  <= '0;
                                    r_next_seq  <= '0;
                                    r_low_slot  <= '0;
                                    r_next_slot <= '0;
                                    r_phase     <= PH_START_WAIT;
                                    r_hs_at     <= r_now;
                                    r_put_type  <= gbn_pkg::SEND_START;
                                    r_put_seq   <= i_cfg.start_token;
                                    r_state     <= S_PUT;
                                end
                            end
                            gbn_pkg::OP_ACK: begin
                                case (r_phase)
                                    PH_START_WAIT: begin
                                        if (ack_seq == i_cfg.start_token) begin
                                            r_phase <= PH_DATA;
                                            r_state <= S_FILL;
                                        end
                                    end
                                    PH_DATA: begin
                                        if (ack_ok) begin
                                            r_low_mark <= ack_seq;
                                            r_low_slot <= ack_slot;
                                            r_state    <= S_FILL;
                                        end
                                    end
                                    PH_END_WAIT: begin
                                        if (ack_seq == i_cfg.end_token) begin
                                            r_phase    <= PH_IDLE;
                                            r_put_type <= gbn_pkg::SEND_DONE;
                                            r_put_seq  <= i_cfg.end_token;
                                            r_state    <= S_PUT;
                                        end
                                    end
                                    default: begin
                                        r_state <= S_IDLE;
                                    end
                                endcase
                            end
                            gbn_pkg::OP_TICK: begin
                                // advance time; the oldest send time is read meanwhile
                                r_now   <= r_now + 1'b1;
                                r_state <= S_TICK;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_TICK: begin
                    r_state <= S_IDLE;
                    case (r_phase)
                        PH_START_WAIT, PH_END_WAIT: begin
                            if (hs_age >= tout) begin
                                r_hs_at    <= r_now;
                                r_put_type <= (r_phase == PH_START_WAIT) ?
                                              gbn_pkg::SEND_START : gbn_pkg::SEND_END;
                                r_put_seq  <= (r_phase == PH_START_WAIT) ?
                                              i_cfg.start_token : i_cfg.end_token;
                                r_state    <= S_PUT;
                            end
                        end
                        PH_DATA: begin
                            if ((outst != '0) && (ring_age >= tout)) begin
                                r_cur_seq  <= r_low_mark;
                                r_cur_slot <= r_low_slot;
                                r_cnt      <= outst;
                                r_state    <= S_RESEND;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_FILL: begin
                    if (!can_send) begin
                        if (outst == '0) begin
                            // window drained: open the END handshake
                            if (out_free) begin
                                r_out_valid <= 1'b1;
                                r_out_type  <= gbn_pkg::SEND_END;
                                r_out_seq   <= i_cfg.end_token;
                                r_out_last  <= 1'b1;
                                r_phase     <= PH_END_WAIT;
                                r_hs_at     <= r_now;
                                r_state     <= S_IDLE;
                            end
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_type  <= gbn_pkg::SEND_DATA;
                        r_out_seq   <= r_next_seq;
                        r_out_last  <= !can_send_more;
                        r_next_seq  <= seq_inc;
                        r_next_slot <= slot_inc(r_next_slot);
                        if (!can_send_more) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RESEND: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_type  <= gbn_pkg::SEND_DATA;
                        r_out_seq   <= r_cur_seq;
                        r_out_last  <= (r_cnt == CNT_W'(1));
                        r_cur_seq   <= r_cur_seq + 1'b1;
                        r_cur_slot  <= slot_inc(r_cur_slot);
                        r_cnt       <= r_cnt - 1'b1;
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_type  <= r_put_type;
                        r_out_seq   <= r_put_seq;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.send_type = r_out_type;
    assign o_out.send_seq  = r_out_seq;
    assign o_out.last      = r_out_last;

    `GBN_ASSERT_ALWAYS(a_span_bound, i_clk, i_rst_n, seq_span <= SPAN_MAX)
    `GBN_ASSERT_IMPLY(a_quiet_window, i_clk, i_rst_n, r_phase != PH_DATA, r_next_seq == r_low_mark)
    `GBN_ASSERT_NEXT(a_stamp_beat, i_clk, i_rst_n, ram_we, r_out_valid && (r_out_type == gbn_pkg::SEND_DATA))
    `GBN_ASSERT_IMPLY(a_resend_count, i_clk, i_rst_n, r_state == S_RESEND, r_cnt != '0)

endmodule

@@ hw/rtl/go_back_n_sender_control_core.sv @@
// Top level of the go-back-N sender control core
//
//   Port       Dir   Payload                          Beat taken when
//   i_in       in    kind, rx_type, rx_seq            valid && ready
//   o_out      out   send_type, send_seq, last        valid && ready
//   i_cfg_*    in    i_cfg_idx, i_cfg_data            i_cfg_we
//
// An event passes an input stage and a two-entry queue before the executor.
// Executor: begin or END ACK passes a put state; START or window ACK a fill state (DATA
// beats while the window allows, END once drained); a tick the tick state (timestamp RAM
// read of the oldest packet), then on timeout a resend of the outstanding beats. Sends leave
// at most one per cycle through the output register. Reset (synchronous) clears phase,
// sequence marks and time and loads register defaults; the timestamp RAM is not cleared.
// An output stall holds the executor; the queue then fills and i_in.ready drops.
module go_back_n_sender_control_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    gbn_in_if.sink                             i_in,
    gbn_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    gbn_pkg::t_cfg      r_cfg;
    gbn_pkg::t_cmd_beat enq;
    gbn_pkg::t_cmd_beat deq;
    logic               q_full;
    logic               pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_size      <= gbn_pkg::WIN_SIZE_RST;
            r_cfg.chunk_count   <= gbn_pkg::CHUNK_COUNT_RST;
            r_cfg.timeout_ticks <= gbn_pkg::TIMEOUT_TICKS_RST;
            r_cfg.start_token   <= gbn_pkg::START_TOKEN_RST;
            r_cfg.end_token     <= gbn_pkg::END_TOKEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gbn_pkg::REG_WIN_SIZE: begin
                    r_cfg.win_size <= i_cfg_data[gbn_pkg::WIN_W-1:0];
                end
                gbn_pkg::REG_CHUNK_COUNT: begin
                    r_cfg.chunk_count <= i_cfg_data[gbn_pkg::CHUNK_W-1:0];
                end
                gbn_pkg::REG_TIMEOUT_TICKS: begin
                    r_cfg.timeout_ticks <= i_cfg_data[gbn_pkg::TOUT_W-1:0];
                end
                gbn_pkg::REG_START_TOKEN: begin
                    r_cfg.start_token <= i_cfg_data[gbn_pkg::TOKEN_W-1:0];
                end
                gbn_pkg::REG_END_TOKEN: begin
                    r_cfg.end_token <= i_cfg_data[gbn_pkg::TOKEN_W-1:0];
                end
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    gbn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_enq   (enq)
    );

    gbn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .o_full  (q_full),
        .o_deq   (deq),
        .i_pop   (pop)
    );

    gbn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_deq   (deq),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
